[sv/two_zone_passage_direction_counter_assert.svh]
// ----------------------------------------------------------------------------
// Two-zone passage direction counter: assertion macros
// Shared property forms used by the counter's assertions.
// ----------------------------------------------------------------------------
`ifndef TWO_ZONE_PASSAGE_DIRECTION_COUNTER_ASSERT_SVH
`define TWO_ZONE_PASSAGE_DIRECTION_COUNTER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define TZPDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define TZPDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/tzpdc_pkg.sv]
// ----------------------------------------------------------------------------
// Two-zone passage direction counter package
// Codes, field widths and helpers of the passage counter.
// ----------------------------------------------------------------------------
package tzpdc_pkg;

  typedef logic [1:0] op_t;
  localparam op_t OP_SAMPLE = 2'd0;
  localparam op_t OP_LOAD   = 2'd1;
  localparam op_t OP_CLEAR  = 2'd2;

  typedef logic [1:0] event_t;
  localparam event_t EV_NONE    = 2'd0;
  localparam event_t EV_ENTRY   = 2'd1;
  localparam event_t EV_EXIT    = 2'd2;
  localparam event_t EV_TIMEOUT = 2'd3;

  typedef logic [1:0] zone_t;
  localparam zone_t ZONE_NONE  = 2'd0;
  localparam zone_t ZONE_LEFT  = 2'd1;
  localparam zone_t ZONE_RIGHT = 2'd2;
  localparam zone_t ZONE_BOTH  = 2'd3;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_INVERT   = 3'd0;
  localparam cfg_idx_t CFG_TIMEOUT  = 3'd1;
  localparam cfg_idx_t CFG_COOLDOWN = 3'd2;
  localparam cfg_idx_t CFG_PEAK_GAP = 3'd3;
  localparam cfg_idx_t CFG_CLAMP    = 3'd4;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 104;
  localparam int CFG_DATA_W = 16;

  typedef logic signed [16:0] balance_t;
  localparam balance_t BALANCE_MIN = 17'sd120;
  localparam logic [15:0] PEAK_NONE = 16'hFFFF;

  localparam logic [31:0] COUNT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] COUNT_MIN = 32'h8000_0000;

  function automatic logic [31:0] clamp_count(input logic en, input logic [31:0] v);
    logic [31:0] r;
    r = v;
    if (en && v[31]) begin
      r = '0;
    end
    return r;
  endfunction

endpackage

[sv/two_zone_passage_direction_counter.sv]
// ----------------------------------------------------------------------------
// Two-zone passage direction counter
// Tracks passages through two ranging zones and counts entries and exits.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Content
//  in_     | slave     | in_tvalid/in_tready  | one sample, load or clear item
//  out_    | master    | out_tvalid/out_tready| event, counts, presence
//  cfg_    | slave     | cfg_valid/cfg_ready  | register index and value
//
// Each item is captured in the input register and then resolved into the
// result register; one item per cycle is sustained unless the output stalls.
// The passage state loop (registered state to next state) sets this rate.
// Reset is synchronous and active low and clears the valid flags, the
// settings, the counters and the passage state.
// A stalled output holds its result; the input register keeps accepting as
// long as its item can move on into the result register.
module two_zone_passage_direction_counter (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // [0] entry_occupied, [1] exit_occupied, [17:2] entry_distance,
  // [33:18] exit_distance, [65:34] timestamp_ms, [97:66] count_value
  input  logic [tzpdc_pkg::IN_DATA_W-1:0]        in_tdata,
  // [1:0] operation
  input  logic [1:0]                             in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // [1:0] event_res, [33:2] head_count, [34] presence,
  // [66:35] entries_today, [98:67] exits_today
  output logic [tzpdc_pkg::OUT_DATA_W-1:0]       out_tdata,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [2:0]                             cfg_index,
  input  logic [tzpdc_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import tzpdc_pkg::*;

  `include "two_zone_passage_direction_counter_assert.svh"

  logic        in_v_r;
  op_t         op_r;
  logic        eo_r, xo_r;
  logic [15:0] ed_r, xd_r;
  logic [31:0] ts_r, cv_r;

  logic                  out_v_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic        inv_r, clamp_r;
  logic [15:0] tmo_r;
  logic [13:0] cool_r;
  logic [10:0] gap_r;

  logic        trk_r, trk_nxt;
  zone_t       prev_r, prev_nxt, fsz_r, fsz_nxt, lsz_r, lsz_nxt;
  logic        sawb_r, sawb_nxt, bwo_r, bwo_nxt;
  logic [15:0] lpd_r, lpd_nxt, rpd_r, rpd_nxt;
  logic [31:0] lpt_r, lpt_nxt, rpt_r, rpt_nxt;
  balance_t    sbal_r, sbal_nxt, ebal_r, ebal_nxt;
  logic [31:0] lchg_r, lchg_nxt, lcnt_r, lcnt_nxt;
  logic [31:0] ppl_r, ppl_nxt, ent_r, ent_nxt, ext_r, ext_nxt;

  logic        adv, cfg_wr;
  logic        lo, ro;
  logic [15:0] ld, rd;
  zone_t       st;
  balance_t    bal;
  zone_t       e_prev, e_fsz, e_lsz;
  logic        e_sawb, e_bwo;
  logic [15:0] e_lpd, e_rpd;
  logic [31:0] e_lpt, e_rpt, e_lchg;
  logic        timed_out, cool_ok;
  logic        order_in, order_out, peak_ok, peak_in, bal_in, bal_out;
  logic        dec_in, dec_out;
  logic [31:0] gap;
  event_t      ev;
  logic        pres;

  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  assign lo = inv_r ? xo_r : eo_r;
  assign ro = inv_r ? eo_r : xo_r;
  assign ld = inv_r ? xd_r : ed_r;
  assign rd = inv_r ? ed_r : xd_r;
  assign st = {ro, lo};
  assign bal = $signed({1'b0, rd}) - $signed({1'b0, ld});

  // A passage that is not open starts from the cleared state at this sample.
  assign e_prev = trk_r ? prev_r : st;
  assign e_fsz  = trk_r ? fsz_r  : ZONE_NONE;
  assign e_lsz  = trk_r ? lsz_r  : ZONE_NONE;
  assign e_sawb = trk_r && sawb_r;
  assign e_bwo  = trk_r && bwo_r;
  assign e_lpd  = trk_r ? lpd_r  : PEAK_NONE;
  assign e_rpd  = trk_r ? rpd_r  : PEAK_NONE;
  assign e_lpt  = trk_r ? lpt_r  : '0;
  assign e_rpt  = trk_r ? rpt_r  : '0;
  assign e_lchg = trk_r ? lchg_r : ts_r;

  assign timed_out = (tmo_r != '0) && ((ts_r - e_lchg) > {16'd0, tmo_r});
  assign cool_ok   = (ts_r - lcnt_r) >= {18'd0, cool_r};

  assign order_in  = (fsz_r == ZONE_RIGHT) && (lsz_r == ZONE_LEFT);
  assign order_out = (fsz_r == ZONE_LEFT) && (lsz_r == ZONE_RIGHT);
  assign gap       = (lpt_r > rpt_r) ? (lpt_r - rpt_r) : (rpt_r - lpt_r);
  assign peak_ok   = (lpt_r != '0) && (rpt_r != '0) && (gap >= {21'd0, gap_r});
  assign peak_in   = rpt_r < lpt_r;
  assign bal_in    = bwo_r && (sbal_r <= -BALANCE_MIN) && (ebal_r >= BALANCE_MIN);
  assign bal_out   = bwo_r && (sbal_r >= BALANCE_MIN) && (ebal_r <= -BALANCE_MIN);
  assign dec_in    = sawb_r && (order_in || (!order_out && (peak_ok ? peak_in : bal_in)));
  assign dec_out   = sawb_r && (order_out || (!order_in && (peak_ok ? !peak_in : bal_out)));

  always_comb begin
    trk_nxt  = trk_r;
    prev_nxt = prev_r;
    fsz_nxt  = fsz_r;
    lsz_nxt  = lsz_r;
    sawb_nxt = sawb_r;
    bwo_nxt  = bwo_r;
    lpd_nxt  = lpd_r;
    rpd_nxt  = rpd_r;
    lpt_nxt  = lpt_r;
    rpt_nxt  = rpt_r;
    sbal_nxt = sbal_r;
    ebal_nxt = ebal_r;
    lchg_nxt = lchg_r;
    lcnt_nxt = lcnt_r;
    ppl_nxt  = ppl_r;
    ent_nxt  = ent_r;
    ext_nxt  = ext_r;
    ev       = EV_NONE;
    pres     = 1'b0;
    if (adv) begin
      case (op_r)
        OP_SAMPLE: begin
          pres = (st != ZONE_NONE);
          if (trk_r || st != ZONE_NONE) begin
            if (timed_out) begin
              ev       = EV_TIMEOUT;
              trk_nxt  = 1'b0;
              lchg_nxt = ts_r;
            end else begin
              trk_nxt  = (st != ZONE_NONE);
              sawb_nxt = e_sawb || (st == ZONE_BOTH);
              fsz_nxt  = e_fsz;
              lsz_nxt  = e_lsz;
              if (st == ZONE_LEFT || st == ZONE_RIGHT) begin
                if (e_fsz == ZONE_NONE) begin
                  fsz_nxt = st;
                end
                lsz_nxt = st;
              end
              lpd_nxt = e_lpd;
              lpt_nxt = e_lpt;
              if (lo && ld != '0 && ld < e_lpd) begin
                lpd_nxt = ld;
                lpt_nxt = ts_r;
              end
              rpd_nxt = e_rpd;
              rpt_nxt = e_rpt;
              if (ro && rd != '0 && rd < e_rpd) begin
                rpd_nxt = rd;
                rpt_nxt = ts_r;
              end
              bwo_nxt  = e_bwo;
              sbal_nxt = trk_r ? sbal_r : '0;
              ebal_nxt = trk_r ? ebal_r : '0;
              if (st != ZONE_NONE && ld != '0 && rd != '0) begin
                if (!e_bwo) begin
                  sbal_nxt = bal;
                end
                bwo_nxt  = 1'b1;
                ebal_nxt = bal;
              end
              prev_nxt = st;
              lchg_nxt = (st != e_prev) ? ts_r : e_lchg;
              if (st == ZONE_NONE && (dec_in || dec_out) && cool_ok) begin
                lcnt_nxt = ts_r;
                if (dec_in) begin
                  ev      = EV_ENTRY;
                  ent_nxt = ent_r + 32'd1;
                  ppl_nxt = clamp_count(clamp_r, (ppl_r == COUNT_MAX) ? ppl_r : ppl_r + 32'd1);
                end else begin
                  ev      = EV_EXIT;
                  ext_nxt = ext_r + 32'd1;
                  ppl_nxt = clamp_count(clamp_r, (ppl_r == COUNT_MIN) ? ppl_r : ppl_r - 32'd1);
                end
              end
            end
          end
        end
        OP_LOAD: begin
          ppl_nxt = clamp_count(clamp_r, cv_r);
        end
        OP_CLEAR: begin
          ent_nxt = '0;
          ext_nxt = '0;
        end
        default: begin
        end
      endcase
    end else if (cfg_wr && cfg_index == CFG_CLAMP) begin
      ppl_nxt = clamp_count(cfg_data[0], ppl_r);
    end
    out_data_nxt = {5'd0, ext_nxt, ent_nxt, pres, ppl_nxt, ev};
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r <= in_tuser;
      eo_r <= in_tdata[0];
      xo_r <= in_tdata[1];
      ed_r <= in_tdata[17:2];
      xd_r <= in_tdata[33:18];
      ts_r <= in_tdata[65:34];
      cv_r <= in_tdata[97:66];
    end
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      inv_r   <= 1'b0;
      tmo_r   <= '0;
      cool_r  <= '0;
      gap_r   <= '0;
      clamp_r <= 1'b0;
      trk_r   <= 1'b0;
      prev_r  <= ZONE_NONE;
      fsz_r   <= ZONE_NONE;
      lsz_r   <= ZONE_NONE;
      sawb_r  <= 1'b0;
      bwo_r   <= 1'b0;
      lpd_r   <= PEAK_NONE;
      rpd_r   <= PEAK_NONE;
      lpt_r   <= '0;
      rpt_r   <= '0;
      sbal_r  <= '0;
      ebal_r  <= '0;
      lchg_r  <= '0;
      lcnt_r  <= '0;
      ppl_r   <= '0;
      ent_r   <= '0;
      ext_r   <= '0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_wr) begin
        case (cfg_index)
          CFG_INVERT:   inv_r   <= cfg_data[0];
          CFG_TIMEOUT:  tmo_r   <= cfg_data;
          CFG_COOLDOWN: cool_r  <= cfg_data[13:0];
          CFG_PEAK_GAP: gap_r   <= cfg_data[10:0];
          CFG_CLAMP:    clamp_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
      trk_r  <= trk_nxt;
      prev_r <= prev_nxt;
      fsz_r  <= fsz_nxt;
      lsz_r  <= lsz_nxt;
      sawb_r <= sawb_nxt;
      bwo_r  <= bwo_nxt;
      lpd_r  <= lpd_nxt;
      rpd_r  <= rpd_nxt;
      lpt_r  <= lpt_nxt;
      rpt_r  <= rpt_nxt;
      sbal_r <= sbal_nxt;
      ebal_r <= ebal_nxt;
      lchg_r <= lchg_nxt;
      lcnt_r <= lcnt_nxt;
      ppl_r  <= ppl_nxt;
      ent_r  <= ent_nxt;
      ext_r  <= ext_nxt;
    end
  end

  `TZPDC_ASSERT_NEXT(a_entry_counts, adv && ev == EV_ENTRY, ent_r == $past(ent_r) + 32'd1, "entry event without entry count")
  `TZPDC_ASSERT_NEXT(a_exit_counts, adv && ev == EV_EXIT, ext_r == $past(ext_r) + 32'd1, "exit event without exit count")
  `TZPDC_ASSERT_NEXT(a_timeout_closes, adv && ev == EV_TIMEOUT, !trk_r, "passage still open after timeout")
  `TZPDC_ASSERT_NOW(a_clamp_holds, clamp_r, !ppl_r[31], "negative count while clamping")

endmodule
